>>> rtl/core/trwq_pkg.sv
// ---------------------------------------------------------------------------
// trwq_pkg
// Shared types and codes for the timed-release wait queues.
// ---------------------------------------------------------------------------
package trwq_pkg;

  localparam int NUM_QUEUES = 3;

  // command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  // queue codes
  localparam logic [1:0] Q_INPUT   = 2'd0;
  localparam logic [1:0] Q_OUTPUT  = 2'd1;
  localparam logic [1:0] Q_PRINTER = 2'd2;
  localparam logic [1:0] Q_NONE    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } fsm_t;

endpackage

>>> rtl/core/timed_release_wait_queues.sv
// ---------------------------------------------------------------------------
// timed_release_wait_queues
// Three FIFO wait queues of blocked tasks sharing one entry memory. A tick
// visits the queues in order and releases heads whose block time is over.
// ---------------------------------------------------------------------------
//  channel   handshake           fields
//  input     start / busy        in_cmd, in_queue_select, in_task_id,
//                                in_block_ticks, in_wait_in
//  result    out_valid strobe    out_queue_index, out_task_out,
//                                out_wait_out, out_last
//
//  Enqueue: written straight into the entry memory; busy stays low.
//  Tick: busy through a read state and an evaluate state per queue, then a
//  final flush state that drives the last release. Up to three result
//  beats, each one cycle wide; the receiver cannot stall them.
//  Waiting time is not walked: each entry keeps a stamp of its queue's
//  non-release tick count, and the head's wait is rebuilt at release.
//  Reset (rst_n low, synchronous) empties all queues; no clearing pass.
// ---------------------------------------------------------------------------
module timed_release_wait_queues #(
  parameter int QUEUE_DEPTH = 16,
  parameter int WAIT_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [1:0]  in_queue_select,
  input  logic [7:0]  in_task_id,
  input  logic [7:0]  in_block_ticks,
  input  logic [15:0] in_wait_in,
  output logic        out_valid,
  output logic [1:0]  out_queue_index,
  output logic [7:0]  out_task_out,
  output logic [15:0] out_wait_out,
  output logic        out_last
);
  import trwq_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = PTR_W + 1;
  // a task sees at most QUEUE_DEPTH * 255 non-release ticks in a queue
  localparam int CNT_W  = PTR_W + 9;
  localparam int ADDR_W = PTR_W + 2;
  localparam int MEM_DEPTH = 4 << PTR_W;
  localparam int SUM_A  = (WAIT_BITS > CNT_W) ? WAIT_BITS : CNT_W;
  localparam int SUM_W  = ((SUM_A > 16) ? SUM_A : 16) + 1;

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]  WAIT_MAX  = SUM_W'((64'd1 << WAIT_BITS) - 64'd1);
  localparam logic [SUM_W-1:0]  OUT_MAX   = SUM_W'(16'hFFFF);

  typedef struct packed {
    logic [7:0]           task_id;
    logic [7:0]           dur;
    logic [WAIT_BITS-1:0] wait_val;
    logic [CNT_W-1:0]     stamp;
  } entry_t;

  // entry memory, one row block per queue
  entry_t mem [MEM_DEPTH];
  entry_t mem_rdata_r;
  entry_t mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  fsm_t state_r, state_nxt;
  logic [1:0] q_r, q_nxt;

  logic [PTR_W-1:0]  rp_r     [NUM_QUEUES];
  logic [PTR_W-1:0]  rp_nxt   [NUM_QUEUES];
  logic [PTR_W-1:0]  wp_r     [NUM_QUEUES];
  logic [PTR_W-1:0]  wp_nxt   [NUM_QUEUES];
  logic [FILL_W-1:0] fill_r   [NUM_QUEUES];
  logic [FILL_W-1:0] fill_nxt [NUM_QUEUES];
  logic [7:0]        elap_r   [NUM_QUEUES];
  logic [7:0]        elap_nxt [NUM_QUEUES];
  logic [CNT_W-1:0]  age_r    [NUM_QUEUES];
  logic [CNT_W-1:0]  age_nxt  [NUM_QUEUES];

  logic        pend_valid_r, pend_valid_nxt;
  logic [1:0]  pend_q_r, pend_q_nxt;
  logic [7:0]  pend_task_r, pend_task_nxt;
  logic [15:0] pend_wait_r, pend_wait_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_q_r;
  logic [7:0]  out_task_r;
  logic [15:0] out_wait_r;
  logic        out_last_r, out_last_nxt;

  logic             accept;
  logic             head_hit;
  logic             release_hit;
  logic [SUM_W-1:0] wait_sum;
  logic [SUM_W-1:0] wait_sat;
  logic [15:0]      wait16;
  logic [SUM_W-1:0] wait_in_ext;
  logic [CNT_W-1:0] age_diff;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  assign mem_raddr = {q_r, rp_r[q_r]};

  // head wait = carried wait + non-release ticks since entry, saturated
  assign age_diff    = age_r[q_r] - mem_rdata_r.stamp;
  assign wait_sum    = SUM_W'(mem_rdata_r.wait_val) + SUM_W'(age_diff);
  assign wait_sat    = (wait_sum > WAIT_MAX) ? WAIT_MAX : wait_sum;
  assign wait16      = (wait_sat > OUT_MAX) ? 16'hFFFF : wait_sat[15:0];
  assign head_hit    = (fill_r[q_r] != '0);
  assign release_hit = head_hit && (elap_r[q_r] == mem_rdata_r.dur);

  // next state
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_TICK) begin
          state_nxt = S_READ;
          q_nxt     = Q_INPUT;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (q_r == Q_PRINTER) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_READ;
          q_nxt     = q_r + 2'd1;
        end
      end
      S_FLUSH: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    elap_nxt = elap_r;
    age_nxt  = age_r;

    pend_valid_nxt = pend_valid_r;
    pend_q_nxt     = pend_q_r;
    pend_task_nxt  = pend_task_r;
    pend_wait_nxt  = pend_wait_r;

    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;

    mem_we      = 1'b0;
    mem_waddr   = {in_queue_select, wp_r[0]};
    wait_in_ext = SUM_W'(in_wait_in);
    mem_wdata.task_id  = in_task_id;
    mem_wdata.dur      = in_block_ticks;
    mem_wdata.wait_val = (wait_in_ext > WAIT_MAX) ? WAIT_MAX[WAIT_BITS-1:0]
                                                  : wait_in_ext[WAIT_BITS-1:0];
    mem_wdata.stamp    = age_r[0];

    case (state_r)
      S_IDLE: begin
        if (accept && in_cmd == CMD_ENQUEUE && in_queue_select != Q_NONE) begin
          mem_waddr       = {in_queue_select, wp_r[in_queue_select]};
          mem_wdata.stamp = age_r[in_queue_select];
          if (fill_r[in_queue_select] != FILL_FULL) begin
            mem_we = 1'b1;
            wp_nxt[in_queue_select] = (wp_r[in_queue_select] == PTR_LAST) ? '0
                                      : wp_r[in_queue_select] + 1'b1;
            fill_nxt[in_queue_select] = fill_r[in_queue_select] + 1'b1;
          end
        end
      end
      S_EVAL: begin
        if (release_hit) begin
          // previous release goes out now, this one waits to learn if last
          out_valid_nxt  = pend_valid_r;
          pend_valid_nxt = 1'b1;
          pend_q_nxt     = q_r;
          pend_task_nxt  = mem_rdata_r.task_id;
          pend_wait_nxt  = wait16;
          rp_nxt[q_r]    = (rp_r[q_r] == PTR_LAST) ? '0 : rp_r[q_r] + 1'b1;
          fill_nxt[q_r]  = fill_r[q_r] - 1'b1;
          elap_nxt[q_r]  = '0;
        end else if (head_hit) begin
          elap_nxt[q_r] = elap_r[q_r] + 8'd1;
          age_nxt[q_r]  = age_r[q_r] + 1'b1;
        end
      end
      S_FLUSH: begin
        out_valid_nxt  = pend_valid_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      q_r          <= Q_INPUT;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rp_r[i]   <= '0;
        wp_r[i]   <= '0;
        fill_r[i] <= '0;
        elap_r[i] <= '0;
        age_r[i]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      q_r          <= q_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      out_last_r   <= out_last_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      elap_r       <= elap_nxt;
      age_r        <= age_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    pend_q_r    <= pend_q_nxt;
    pend_task_r <= pend_task_nxt;
    pend_wait_r <= pend_wait_nxt;
    out_q_r     <= pend_q_r;
    out_task_r  <= pend_task_r;
    out_wait_r  <= pend_wait_r;
  end

  assign out_valid       = out_valid_r;
  assign out_queue_index = out_q_r;
  assign out_task_out    = out_task_r;
  assign out_wait_out    = out_wait_r;
  assign out_last        = out_last_r;

endmodule
